### hw/rtl/elmf_pkg.sv
// ----------------------------------------------------------------------------
// elmf_pkg
// Types and constants shared by the electrode level mode filter blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package elmf_pkg;

    typedef logic [2:0] t_code;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [6:0]  electrodes;
        logic        link_up;
        logic        force_request;
    } t_in_item;

    typedef struct packed {
        logic [6:0] level_percent;
        t_code      level_code;
        logic       was_forced;
        logic       from_mode;
    } t_out_item;

    // status from the mode counting unit
    typedef struct packed {
        logic  done;
        t_code code;
    } t_mode_status;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 56;

    localparam logic [CFG_IDX_W-1:0] CFG_READ_INTERVAL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_THRESH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERCENT_TABLE   = 2'd3;

    localparam logic [31:0] READ_INTERVAL_RST   = 32'd1000;
    localparam logic [31:0] REPORT_INTERVAL_RST = 32'd5000;
    localparam logic [6:0]  CHANGE_THRESH_RST   = 7'd1;
    localparam logic [6:0]  PERCENT_MAX         = 7'd100;
    localparam t_code       CODE_NONE           = 3'd0;
    localparam t_code       CODE_LAST           = 3'd7;

endpackage

`default_nettype wire

### hw/rtl/electrode_level_mode_filter.sv
// ----------------------------------------------------------------------------
// electrode_level_mode_filter
// Electrode level sensing with a mode filter over recent readings and
// change-gated reporting.
// ----------------------------------------------------------------------------
// usage:
//   input requests carry time, electrode bits, link status and a force request;
//   o_in_stall is high while a request is in work. result requests leave
//   through an output register and are held there while i_out_stall is high.
//   a request with the link down ends in the idle state; a reading that
//   is not due ends at the read step; one without a report ends at the
//   report step. a raw forced report goes from the report step straight
//   to the publish step; a mode report first passes the mode step, the
//   mode unit stepping over the 8 possible codes one per cycle.
//   if the previous result is still stalled in the output register the
//   block waits at the publish step until it is taken.
//   configuration writes go straight into the registers and are meant for
//   idle time only.
//   reset (synchronous, active low) clears the history, counters, times,
//   force and link state and loads the register defaults; no result is
//   pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module electrode_level_mode_filter
    import elmf_pkg::*;
#(
    parameter int HISTORY_DEPTH   = 5,
    parameter int ELECTRODE_COUNT = 7
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_item         i_in_data,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output t_out_item             o_out_data,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int WPW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SCW = $clog2(HISTORY_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_RPT,
        S_MODE,
        S_PUB
    } t_state;

    t_state           r_state;
    logic [31:0]      r_read_interval;
    logic [31:0]      r_report_interval;
    logic [6:0]       r_thresh;
    logic [55:0]      r_table;

    t_code            r_hist [HISTORY_DEPTH];
    logic [WPW-1:0]   r_wp;
    logic [SCW-1:0]   r_sample_cnt;
    logic [31:0]      r_last_read;
    logic [31:0]      r_last_report;
    logic [6:0]       r_last_pct;
    logic             r_reported_once;
    logic             r_force_pending;
    logic             r_link_was_up;

    logic [31:0]      r_now;
    logic [6:0]       r_bits;
    logic             r_forced;
    logic             r_from_mode;
    t_code            r_code;
    logic             r_mode_start;

    logic             n_force_pending;
    t_code            raw_code;
    logic             read_due;
    logic             report_due;
    logic             hist_full;
    logic [63:0]      table_ext;
    logic [7:0]       pct_byte;
    logic [6:0]       pct;
    logic [6:0]       diff;
    logic             suppress;
    logic             out_free;
    logic             pub_fire;
    t_mode_status     mode_st;

    elmf_mode_unit #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_mode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_mode_start),
        .i_hist   (r_hist),
        .o_status (mode_st)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign n_force_pending = r_force_pending || i_in_data.force_request ||
                             (i_in_data.link_up && !r_link_was_up);

    // highest covered electrode
    always_comb begin
        raw_code = CODE_NONE;
        for (int i = 0; i < ELECTRODE_COUNT; i++) begin
            if (r_bits[i]) begin
                raw_code = 3'(i + 1);
            end
        end
    end

    assign read_due   = ((r_now - r_last_read) > r_read_interval) || r_forced;
    assign report_due = ((r_now - r_last_report) >= r_report_interval) || r_forced;
    assign hist_full  = (r_sample_cnt == SCW'(HISTORY_DEPTH));

    assign table_ext = {8'd0, r_table};
    always_comb begin
        pct_byte = table_ext[{r_code - 3'd1, 3'b000} +: 8];
        if (r_code == CODE_NONE || 32'(r_code) > ELECTRODE_COUNT) begin
            pct = 7'd0;
        end else if (pct_byte > 8'(PERCENT_MAX)) begin
            pct = PERCENT_MAX;
        end else begin
            pct = pct_byte[6:0];
        end
        diff = (pct > r_last_pct) ? (pct - r_last_pct) : (r_last_pct - pct);
        suppress = !r_forced && r_reported_once && (diff < r_thresh);
    end

    assign out_free = !o_out_valid || !i_out_stall;
    assign pub_fire = (r_state == S_PUB) && !suppress && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_read_interval   <= READ_INTERVAL_RST;
            r_report_interval <= REPORT_INTERVAL_RST;
            r_thresh          <= CHANGE_THRESH_RST;
            r_table           <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist[i] <= CODE_NONE;
            end
            r_wp            <= '0;
            r_sample_cnt    <= '0;
            r_last_read     <= '0;
            r_last_report   <= '0;
            r_last_pct      <= '0;
            r_reported_once <= 1'b0;
            r_force_pending <= 1'b0;
            r_link_was_up   <= 1'b0;
            r_forced        <= 1'b0;
            r_from_mode     <= 1'b0;
            r_mode_start    <= 1'b0;
            o_out_valid     <= 1'b0;
        end else begin
            r_mode_start <= (r_state == S_RPT) && hist_full && report_due;
            o_out_valid  <= pub_fire || (o_out_valid && i_out_stall);

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_READ_INTERVAL:   r_read_interval   <= i_cfg_data[31:0];
                    CFG_REPORT_INTERVAL: r_report_interval <= i_cfg_data[31:0];
                    CFG_CHANGE_THRESH:   r_thresh          <= i_cfg_data[6:0];
                    CFG_PERCENT_TABLE:   r_table           <= i_cfg_data;
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_force_pending <= n_force_pending;
                        r_link_was_up   <= i_in_data.link_up;
                        r_forced        <= n_force_pending;
                        r_now           <= i_in_data.now_ms;
                        r_bits          <= i_in_data.electrodes;
                        if (i_in_data.link_up) begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    if (read_due) begin
                        r_last_read   <= r_now;
                        r_hist[r_wp]  <= raw_code;
                        r_code        <= raw_code;
                        r_wp <= (r_wp == WPW'(HISTORY_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                        if (!hist_full) begin
                            r_sample_cnt <= r_sample_cnt + 1'b1;
                        end
                        r_state <= S_RPT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_RPT: begin
                    if (hist_full && report_due) begin
                        r_force_pending <= 1'b0;
                        r_from_mode     <= 1'b1;
                        r_state         <= S_MODE;
                    end else if (r_forced) begin
                        r_force_pending <= 1'b0;
                        r_from_mode     <= 1'b0;
                        r_state         <= S_PUB;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_MODE: begin
                    if (mode_st.done) begin
                        r_code  <= mode_st.code;
                        r_state <= S_PUB;
                    end
                end
                S_PUB: begin
                    if (suppress) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_last_pct      <= pct;
                        r_reported_once <= 1'b1;
                        r_last_report   <= r_now;
                        o_out_data.level_percent <= pct;
                        o_out_data.level_code    <= r_code;
                        o_out_data.was_forced    <= r_forced;
                        o_out_data.from_mode     <= r_from_mode;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/elmf_mode_unit.sv
// ----------------------------------------------------------------------------
// elmf_mode_unit
// Finds the most frequent code in the history ring, one candidate code per
// cycle; ties go to the higher code.
// ----------------------------------------------------------------------------
`default_nettype none

module elmf_mode_unit
    import elmf_pkg::*;
#(
    parameter int HISTORY_DEPTH = 5
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_start,
    input  wire t_code   i_hist [HISTORY_DEPTH],
    output t_mode_status o_status
);

    localparam int CW = $clog2(HISTORY_DEPTH + 1);

    logic          r_busy;
    t_code         r_cand;
    t_code         r_best;
    logic [CW-1:0] r_best_cnt;

    logic [CW-1:0] cnt;
    logic          take;

    // count of entries equal to the current candidate
    always_comb begin
        cnt = '0;
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            cnt = cnt + CW'(i_hist[i] == r_cand);
        end
        take = (cnt != '0) && (cnt >= r_best_cnt);
    end

    always_comb begin
        o_status.done = r_busy && (r_cand == CODE_LAST);
        o_status.code = take ? r_cand : r_best;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_cand     <= CODE_NONE;
            r_best     <= CODE_NONE;
            r_best_cnt <= '0;
        end else if (i_start) begin
            r_busy     <= 1'b1;
            r_cand     <= CODE_NONE;
            r_best     <= CODE_NONE;
            r_best_cnt <= '0;
        end else if (r_busy) begin
            if (take) begin
                r_best     <= r_cand;
                r_best_cnt <= cnt;
            end
            r_cand <= r_cand + 3'd1;
            if (r_cand == CODE_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/elmf_checker.sv
// ----------------------------------------------------------------------------
// elmf_checker
// Port-level checks for the electrode level mode filter.
// ----------------------------------------------------------------------------
`default_nettype none

module elmf_checker
    import elmf_pkg::*;
(
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  o_out_valid,
    input wire                  i_out_stall,
    input wire t_out_item       o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // no result is pending right after reset
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.level_percent <= PERCENT_MAX)
        else $error("percent above 100");

    // raw readings are only reported on a force
    a_raw_forced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.from_mode |-> o_out_data.was_forced)
        else $error("raw report without force");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.level_code == CODE_NONE)
            |-> (o_out_data.level_percent == 7'd0))
        else $error("no electrode covered but nonzero percent");

endmodule

bind electrode_level_mode_filter elmf_checker u_elmf_checker (.*);

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the electrode level mode filter. Each accepted
// request runs through an in-bench level predictor; report requests leaving
// the block are compared in order against the predicted reports.
// ----------------------------------------------------------------------------

module tb;
    import elmf_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 20;
    localparam int RING_DEPTH    = 5;

    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            i_in_valid  = 1'b0;
    logic            o_in_stall;
    t_in_item        i_in_data   = '0;
    logic            o_out_valid;
    logic            i_out_stall = 1'b0;
    t_out_item       o_out_data;
    logic            i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // predictor copy of the registers
    logic [31:0] read_gap_ms   = READ_INTERVAL_RST;
    logic [31:0] report_gap_ms = REPORT_INTERVAL_RST;
    logic [6:0]  min_change    = CHANGE_THRESH_RST;
    logic [55:0] pct_table     = '0;

    // predictor copy of the block state
    t_code       hist_codes [RING_DEPTH];
    int          hist_wr        = 0;
    int          hist_fill      = 0;
    logic [31:0] last_read_ms   = '0;
    logic [31:0] last_report_ms = '0;
    logic [6:0]  last_pct       = '0;
    logic        have_reported  = 1'b0;
    logic        force_armed    = 1'b0;
    logic        link_prev      = 1'b0;

    t_out_item   pending_reports [$];
    int          level_errors   = 0;
    int          cycle_count    = 0;

    // stimulus shaping
    int          send_idle_pct  = 0;
    int          stall_pct      = 0;
    logic        quiet_stretch  = 1'b0;
    int          force_pct      = 5;     // out of 128
    logic [31:0] now_cursor     = '0;
    logic [2:0]  fill_level     = '0;

    electrode_level_mode_filter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= !quiet_stretch && (int'($urandom_range(99)) < stall_pct);
    end

    function automatic bit publish_level(input t_code code, input logic [31:0] now,
                                         input logic forced, input logic from_mode,
                                         output t_out_item res);
        logic [7:0] pct_byte;
        logic [6:0] pct;
        logic [6:0] diff;
        int         idx;
        res = '0;
        idx = code;
        if (code == CODE_NONE) begin
            pct = '0;
        end else begin
            pct_byte = pct_table[8*(idx-1) +: 8];
            pct = (pct_byte > 8'd100) ? PERCENT_MAX : pct_byte[6:0];
        end
        diff = (pct > last_pct) ? pct - last_pct : last_pct - pct;
        if (!forced && have_reported && diff < min_change) begin
            return 1'b0;
        end
        last_pct       = pct;
        have_reported  = 1'b1;
        last_report_ms = now;
        res.level_percent = pct;
        res.level_code    = code;
        res.was_forced    = forced;
        res.from_mode     = from_mode;
        return 1'b1;
    endfunction

    function automatic bit predict_level_report(input t_in_item req, output t_out_item res);
        t_code code;
        t_code best;
        int    best_n;
        int    counts [8];
        logic  forced;
        res = '0;
        if (req.force_request || (req.link_up && !link_prev)) begin
            force_armed = 1'b1;
        end
        link_prev = req.link_up;
        if (!req.link_up) begin
            return 1'b0;
        end
        forced = force_armed;
        if (!((req.now_ms - last_read_ms) > read_gap_ms || forced)) begin
            return 1'b0;
        end
        last_read_ms = req.now_ms;

        // highest covered electrode
        code = CODE_NONE;
        for (int i = 6; i >= 0; i--) begin
            if (req.electrodes[i] && code == CODE_NONE) begin
                code = t_code'(i + 1);
            end
        end
        hist_codes[hist_wr] = code;
        hist_wr = (hist_wr == RING_DEPTH - 1) ? 0 : hist_wr + 1;
        if (hist_fill < RING_DEPTH) begin
            hist_fill++;
        end

        if (hist_fill >= RING_DEPTH &&
            ((req.now_ms - last_report_ms) >= report_gap_ms || forced)) begin
            force_armed = 1'b0;
            for (int c = 0; c < 8; c++) counts[c] = 0;
            for (int i = 0; i < RING_DEPTH; i++) counts[hist_codes[i]]++;
            // ties go to the higher code
            best = CODE_NONE;
            best_n = 0;
            for (int c = 0; c < 8; c++) begin
                if (counts[c] > 0 && counts[c] >= best_n) begin
                    best_n = counts[c];
                    best = t_code'(c);
                end
            end
            return publish_level(best, req.now_ms, forced, 1'b1, res);
        end
        if (forced) begin
            force_armed = 1'b0;
            return publish_level(code, req.now_ms, 1'b1, 1'b0, res);
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin : report_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_reports.size() == 0) begin
                if (level_errors < 10) begin
                    $display("unexpected report: pct %0d code %0d forced %0b mode %0b",
                             o_out_data.level_percent, o_out_data.level_code,
                             o_out_data.was_forced, o_out_data.from_mode);
                end
                level_errors++;
            end else begin
                want = pending_reports.pop_front();
                if (o_out_data.level_percent !== want.level_percent ||
                    o_out_data.level_code !== want.level_code ||
                    o_out_data.was_forced !== want.was_forced ||
                    o_out_data.from_mode !== want.from_mode) begin
                    if (level_errors < 10) begin
                        $display("report mismatch: expected pct %0d code %0d forced %0b mode %0b",
                                 want.level_percent, want.level_code,
                                 want.was_forced, want.from_mode);
                        $display("                 got      pct %0d code %0d forced %0b mode %0b",
                                 o_out_data.level_percent, o_out_data.level_code,
                                 o_out_data.was_forced, o_out_data.from_mode);
                    end
                    level_errors++;
                end
            end
        end
    end

    // entered at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so the caller must send again or settle at once
    task automatic send_level_request(input t_in_item req);
        t_out_item res;
        int        idle;
        idle = quiet_stretch ? 0 : send_idle_pct;
        if (int'($urandom_range(99)) < idle) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
            while (int'($urandom_range(99)) < idle) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (predict_level_report(req, res)) begin
            pending_reports.push_back(res);
        end
        @(negedge i_clk);
    endtask

    // drop valid, wait for every report, then let in-flight work finish
    task automatic settle_level_block();
        i_in_valid <= 1'b0;
        quiet_stretch = 1'b0;
        while (pending_reports.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_level_reg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            CFG_READ_INTERVAL:   read_gap_ms   = value[31:0];
            CFG_REPORT_INTERVAL: report_gap_ms = value[31:0];
            CFG_CHANGE_THRESH:   min_change    = value[6:0];
            CFG_PERCENT_TABLE:   pct_table     = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_in_item level_req(input logic [31:0] now, input logic [6:0] bits,
                                           input logic link, input logic force_req);
        t_in_item req;
        req.now_ms        = now;
        req.electrodes    = bits;
        req.link_up       = link;
        req.force_request = force_req;
        return req;
    endfunction

    // mostly a steady fill column with slowly moving level, some noise
    function automatic t_in_item random_level_request();
        t_in_item    req;
        logic [31:0] rnd;
        logic [7:0]  column;
        rnd = $urandom;
        if (rnd[7:0] < 8'd4) begin
            now_cursor = now_cursor + $urandom;
        end else begin
            now_cursor = now_cursor + {27'd0, rnd[12:8]};
        end
        if (rnd[20:16] < 5'd3) begin
            fill_level = rnd[23:21];
        end
        column = (8'd1 << fill_level) - 8'd1;
        req.now_ms = now_cursor;
        rnd = $urandom;
        req.electrodes    = (rnd[7:0] < 8'd40) ? rnd[14:8] : column[6:0];
        req.link_up       = (rnd[23:16] >= 8'd10);
        req.force_request = (int'(rnd[31:25]) < force_pct);
        return req;
    endfunction

    task automatic stream_random_levels(input int count);
        for (int k = 0; k < count; k++) begin
            quiet_stretch = ((k % 64) < 12);
            send_level_request(random_level_request());
        end
    endtask

    function automatic logic [55:0] random_pct_table(input logic rising);
        logic [55:0] table_bits;
        logic [31:0] rnd;
        logic [7:0]  step_pct;
        table_bits = 56'({$urandom, $urandom});
        if (rising) begin
            step_pct = '0;
            for (int i = 0; i < 7; i++) begin
                rnd = $urandom;
                step_pct = step_pct + {3'd0, rnd[4:0]};
                table_bits[8*i +: 8] = step_pct;
            end
        end
        return table_bits;
    endfunction

    task automatic test_directed();
        send_level_request(level_req(32'd0, 7'h00, 1'b0, 1'b0));
        // force armed while the link is down
        send_level_request(level_req(32'd0, 7'h7f, 1'b0, 1'b1));
        send_level_request(level_req(32'd1, 7'h7f, 1'b1, 1'b0));
        settle_level_block();
        // bytes above 100 and 255 clamp
        write_level_reg(CFG_PERCENT_TABLE, 56'h01_63_32_00_ff_65_64);
        write_level_reg(CFG_READ_INTERVAL, '0);
        write_level_reg(CFG_REPORT_INTERVAL, '0);
        write_level_reg(CFG_CHANGE_THRESH, '0);
        for (int i = 0; i < 7; i++) begin
            send_level_request(level_req(32'd10 + i, 7'h01 << i, 1'b1, 1'b0));
        end
        send_level_request(level_req(32'd17, 7'h00, 1'b1, 1'b0));
        // same time, reading not due
        send_level_request(level_req(32'd17, 7'h7f, 1'b1, 1'b0));
        send_level_request(level_req(32'd18, 7'h40, 1'b1, 1'b1));
        // link drop and return arms a force
        send_level_request(level_req(32'd19, 7'h7f, 1'b0, 1'b0));
        send_level_request(level_req(32'd20, 7'h03, 1'b1, 1'b0));
        // time wraps around
        send_level_request(level_req(32'hffff_ffff, 7'h7f, 1'b1, 1'b0));
        send_level_request(level_req(32'd4, 7'h7f, 1'b1, 1'b0));
        settle_level_block();
        write_level_reg(CFG_CHANGE_THRESH, 56'd127);
        write_level_reg(CFG_REPORT_INTERVAL, 56'hffff_ffff);
        send_level_request(level_req(32'd5, 7'h01, 1'b1, 1'b0));
        send_level_request(level_req(32'd6, 7'h01, 1'b1, 1'b1));
    endtask

    task automatic test_steady_levels();
        logic [31:0] rnd;
        settle_level_block();
        send_idle_pct = 0;
        stall_pct     = 0;
        force_pct     = 5;
        rnd = $urandom;
        write_level_reg(CFG_READ_INTERVAL, {52'd0, rnd[3:0]});
        write_level_reg(CFG_REPORT_INTERVAL, {50'd0, rnd[9:4]});
        write_level_reg(CFG_CHANGE_THRESH, {51'd0, 5'd1 + {1'b0, rnd[13:10]}});
        write_level_reg(CFG_PERCENT_TABLE, random_pct_table(1'b1));
        stream_random_levels(200);
    endtask

    task automatic test_sender_gaps();
        settle_level_block();
        send_idle_pct = 74;
        stall_pct     = 0;
        force_pct     = 5;
        write_level_reg(CFG_READ_INTERVAL, '0);
        write_level_reg(CFG_REPORT_INTERVAL, '0);
        write_level_reg(CFG_CHANGE_THRESH, '0);
        write_level_reg(CFG_PERCENT_TABLE, {56{1'b1}});
        stream_random_levels(200);
    endtask

    task automatic test_receiver_stalls();
        logic [31:0] rnd;
        settle_level_block();
        send_idle_pct = 0;
        stall_pct     = 74;
        force_pct     = 8;
        rnd = $urandom;
        write_level_reg(CFG_READ_INTERVAL, {50'd0, rnd[5:0]});
        write_level_reg(CFG_REPORT_INTERVAL, {48'd0, rnd[13:6]});
        write_level_reg(CFG_CHANGE_THRESH, {49'd0, 7'($urandom_range(100))});
        write_level_reg(CFG_PERCENT_TABLE, random_pct_table(1'b0));
        stream_random_levels(200);
    endtask

    task automatic test_both_sides();
        settle_level_block();
        send_idle_pct = 25;
        stall_pct     = 25;
        // only forced reports get through at the widest intervals
        force_pct     = 24;
        now_cursor    = 32'hffff_ff00;
        write_level_reg(CFG_READ_INTERVAL, 56'hffff_ffff);
        write_level_reg(CFG_REPORT_INTERVAL, 56'hffff_ffff);
        write_level_reg(CFG_CHANGE_THRESH, 56'd127);
        write_level_reg(CFG_PERCENT_TABLE, random_pct_table(1'b0));
        stream_random_levels(200);
    endtask

    initial begin
        for (int i = 0; i < RING_DEPTH; i++) hist_codes[i] = CODE_NONE;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_steady_levels();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_sides();
        settle_level_block();
        if (level_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### electrode_level_mode_filter.f
hw/rtl/elmf_pkg.sv
hw/rtl/elmf_mode_unit.sv
hw/rtl/electrode_level_mode_filter.sv
hw/rtl/elmf_checker.sv
verif/tb.sv
